FILE: rtl/avc_pkg.sv
// Shared types, codes and constants of the arrival velocity controller.
package avc_pkg;

    localparam int CFG_W = 31;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_ARM  = 2'd1;
    localparam logic [1:0] ACT_LOAD = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam logic [2:0] REG_MAX_SPEED  = 3'd0;
    localparam logic [2:0] REG_ACCEL      = 3'd1;
    localparam logic [2:0] REG_DECEL      = 3'd2;
    localparam logic [2:0] REG_TICK_TIME  = 3'd3;
    localparam logic [2:0] REG_ARRIVE     = 3'd4;
    localparam logic [2:0] REG_STOP_SPEED = 3'd5;
    localparam logic [2:0] REG_GAIN       = 3'd6;

    localparam logic [CFG_W-1:0] RST_MAX_SPEED  = 31'd19660800;
    localparam logic [CFG_W-1:0] RST_ACCEL      = 31'd6553600;
    localparam logic [CFG_W-1:0] RST_DECEL      = 31'd6553600;
    localparam logic [CFG_W-1:0] RST_TICK_TIME  = 31'd1092;
    localparam logic [CFG_W-1:0] RST_ARRIVE     = 31'd3932160;
    localparam logic [CFG_W-1:0] RST_STOP_SPEED = 31'd983040;
    localparam logic [CFG_W-1:0] RST_GAIN       = 31'd196608;

    localparam logic [31:0] TINY_DIST     = 32'd6;
    localparam logic [4:0]  CORDIC_LAST   = 5'd23;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [50:0] NORM_LIMIT  = 51'sd2147483647;
    localparam logic [35:0] GAIN_CLAMP    = 36'h200000000;

    typedef enum logic [5:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_SQD, ST_WD, ST_VX, ST_VY, ST_SQV, ST_WV,
        ST_CHK, ST_ARRIVE, ST_DD, ST_SQS, ST_WS, ST_PX, ST_DVX, ST_WX,
        ST_PY, ST_DVY, ST_WY, ST_ERR, ST_WC, ST_F1, ST_F2, ST_F3, ST_F4,
        ST_F5, ST_G1, ST_G2, ST_A1, ST_A2, ST_A3, ST_A4, ST_A5, ST_I1,
        ST_I2, ST_NRM, ST_H1, ST_H2, ST_SQH, ST_WH, ST_CAP, ST_CX, ST_CDX,
        ST_CWX, ST_CY, ST_CDY, ST_CWY, ST_WB, ST_OUT
    } avc_state_t;

    typedef struct packed {
        avc_state_t st;
        logic       load;
        logic       out_load;
    } avc_cmd_t;

    typedef struct packed {
        logic tick_go;
        logic sq_done;
        logic div_done;
        logic cs_done;
        logic arrive;
        logic tiny;
        logic norm_ok;
        logic need_cap;
    } avc_sts_t;

    function automatic logic [29:0] atan_lut(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/avc_sqrt.sv
// Truncated 64-bit integer square root, two radicand bits per cycle.
module avc_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] v_reg, r_reg, b_reg, trial;
    logic        busy_reg, done_reg;

    assign trial = r_reg + b_reg;
    assign done  = done_reg;
    assign root  = r_reg[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && b_reg[0];
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && b_reg[0]) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg <= radicand;
            r_reg <= 64'd0;
            b_reg <= 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + b_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
        end
    end
endmodule

FILE: rtl/avc_div.sv
// Signed 64 by unsigned 32 restoring divider, one quotient bit per cycle.
module avc_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic [31:0]        divisor,
    output logic               done,
    output logic signed [31:0] quot
);
    logic [63:0] n_reg;
    logic [31:0] d_reg;
    logic [32:0] rem_reg, rem_sh;
    logic [5:0]  cnt_reg;
    logic        neg_reg, busy_reg, done_reg, ge;

    assign rem_sh = {rem_reg[31:0], n_reg[63]};
    assign ge     = rem_sh >= {1'b0, d_reg};
    assign done   = done_reg;
    assign quot   = neg_reg ? -$signed(n_reg[31:0]) : $signed(n_reg[31:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 6'd63);
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == 6'd63)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= dividend[63] ? 64'(-dividend) : 64'(dividend);
            neg_reg <= dividend[63];
            d_reg   <= divisor;
            rem_reg <= 33'd0;
            cnt_reg <= 6'd0;
        end else if (busy_reg) begin
            rem_reg <= ge ? rem_sh - {1'b0, d_reg} : rem_sh;
            n_reg   <= {n_reg[62:0], ge};
            cnt_reg <= cnt_reg + 6'd1;
        end
    end
endmodule

FILE: rtl/avc_dp.sv
// Datapath: state, config registers, shared multiplier, CORDIC and arithmetic units.
module avc_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  avc_pkg::avc_cmd_t    cmd,
    output avc_pkg::avc_sts_t    sts,
    input  logic                 cfg_valid,
    input  logic [2:0]           cfg_addr,
    input  logic [30:0]          cfg_data,
    input  logic [143:0]         s_tdata,
    input  logic [1:0]           s_tuser,
    output logic [63:0]          m_tdata,
    output logic [1:0]           m_tuser
);
    logic [30:0] max_reg, acc_lim_reg, dec_lim_reg, tick_reg, arr_reg, stop_reg, gain_reg;

    logic signed [31:0] vx_reg, vy_reg, ox_reg, oy_reg, dvx_reg, dvy_reg;
    logic               armed_reg, arrived_reg, k_reg;
    logic [15:0]        hd_reg;
    logic [63:0]        acc_reg;
    logic signed [69:0] prod_reg;
    logic signed [35:0] mul_a;
    logic signed [33:0] mul_b;
    logic [31:0]        dist_reg, spd_reg, ds_reg, sp_reg;
    logic signed [32:0] ex_reg, ey_reg;
    logic signed [17:0] s_reg, c_reg;
    logic signed [51:0] t_reg, dif, sum;
    logic signed [35:0] fe_reg, re_reg;
    logic signed [31:0] fa_reg, ra_reg;
    logic signed [34:0] ax_reg, ay_reg;
    logic signed [50:0] nx_reg, ny_reg;
    logic [63:0]        mdata_reg;
    logic [1:0]         muser_reg;

    logic               sq_start, sq_done, div_start, div_done;
    logic [63:0]        sq_in;
    logic [31:0]        sq_root, div_d;
    logic signed [63:0] div_n;
    logic signed [31:0] div_q;

    logic signed [33:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;
    logic [4:0]         ci_reg;
    logic [1:0]         cq_reg;
    logic               cbusy_reg, cdone_reg;
    logic [31:0]        ang, ang_rem;
    logic [1:0]         ang_q;
    logic signed [19:0] cs_w, sn_w;
    logic signed [17:0] cs, sn;

    function automatic logic [33:0] gain_mag(input logic signed [35:0] e);
        logic [35:0] m;
        m = e[35] ? 36'(-e) : 36'(e);
        return (m > avc_pkg::GAIN_CLAMP) ? avc_pkg::GAIN_CLAMP[33:0] : m[33:0];
    endfunction

    function automatic logic signed [31:0] clamp_acc(input logic neg, input logic [47:0] p,
                                                     input logic [30:0] pos_lim,
                                                     input logic [30:0] neg_lim);
        logic signed [31:0] r;
        if (neg) begin
            r = (p > 48'(neg_lim)) ? -$signed({1'b0, neg_lim}) : -$signed({1'b0, p[30:0]});
        end else begin
            r = (p > 48'(pos_lim)) ? $signed({1'b0, pos_lim}) : $signed({1'b0, p[30:0]});
        end
        return r;
    endfunction

    assign m_tdata = mdata_reg;
    assign m_tuser = muser_reg;

    assign dif = prod_reg[51:0] - t_reg;
    assign sum = prod_reg[51:0] + t_reg;

    assign sts.tick_go  = (s_tuser == avc_pkg::ACT_TICK) && armed_reg;
    assign sts.sq_done  = sq_done;
    assign sts.div_done = div_done;
    assign sts.cs_done  = cdone_reg;
    assign sts.arrive   = (dist_reg < {1'b0, arr_reg}) && (spd_reg < {1'b0, stop_reg});
    assign sts.tiny     = dist_reg <= avc_pkg::TINY_DIST;
    assign sts.norm_ok  = (nx_reg < avc_pkg::NORM_LIMIT) && (nx_reg > -avc_pkg::NORM_LIMIT) &&
                          (ny_reg < avc_pkg::NORM_LIMIT) && (ny_reg > -avc_pkg::NORM_LIMIT);
    assign sts.need_cap = k_reg || (sp_reg > {1'b0, max_reg});

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.st)
            avc_pkg::ST_SQX: begin mul_a = 36'(ox_reg); mul_b = 34'(ox_reg); end
            avc_pkg::ST_SQY: begin mul_a = 36'(oy_reg); mul_b = 34'(oy_reg); end
            avc_pkg::ST_VX:  begin mul_a = 36'(vx_reg); mul_b = 34'(vx_reg); end
            avc_pkg::ST_VY:  begin mul_a = 36'(vy_reg); mul_b = 34'(vy_reg); end
            avc_pkg::ST_DD: begin
                mul_a = 36'($signed({1'b0, dec_lim_reg}));
                mul_b = $signed({2'b00, dist_reg});
            end
            avc_pkg::ST_PX: begin mul_a = 36'(ox_reg); mul_b = $signed({2'b00, ds_reg}); end
            avc_pkg::ST_PY: begin mul_a = 36'(oy_reg); mul_b = $signed({2'b00, ds_reg}); end
            avc_pkg::ST_F1: begin mul_a = 36'(ex_reg); mul_b = 34'(s_reg); end
            avc_pkg::ST_F2: begin mul_a = 36'(ey_reg); mul_b = 34'(c_reg); end
            avc_pkg::ST_F3: begin mul_a = 36'(ex_reg); mul_b = 34'(c_reg); end
            avc_pkg::ST_F4: begin mul_a = 36'(ey_reg); mul_b = 34'(s_reg); end
            avc_pkg::ST_F5: begin
                mul_a = $signed({2'b00, gain_mag(fe_reg)});
                mul_b = 34'($signed({1'b0, gain_reg}));
            end
            avc_pkg::ST_G1: begin
                mul_a = $signed({2'b00, gain_mag(re_reg)});
                mul_b = 34'($signed({1'b0, gain_reg}));
            end
            avc_pkg::ST_A1: begin mul_a = 36'(fa_reg); mul_b = 34'(s_reg); end
            avc_pkg::ST_A2: begin mul_a = 36'(ra_reg); mul_b = 34'(c_reg); end
            avc_pkg::ST_A3: begin mul_a = 36'(fa_reg); mul_b = 34'(c_reg); end
            avc_pkg::ST_A4: begin mul_a = 36'(ra_reg); mul_b = 34'(s_reg); end
            avc_pkg::ST_A5: begin mul_a = 36'(ax_reg); mul_b = 34'($signed({1'b0, tick_reg})); end
            avc_pkg::ST_I1: begin mul_a = 36'(ay_reg); mul_b = 34'($signed({1'b0, tick_reg})); end
            avc_pkg::ST_H1: begin
                mul_a = 36'($signed(nx_reg[31:0]));
                mul_b = 34'($signed(nx_reg[31:0]));
            end
            avc_pkg::ST_H2: begin
                mul_a = 36'($signed(ny_reg[31:0]));
                mul_b = 34'($signed(ny_reg[31:0]));
            end
            avc_pkg::ST_CX: begin
                mul_a = 36'($signed(nx_reg[31:0]));
                mul_b = 34'($signed({1'b0, max_reg}));
            end
            avc_pkg::ST_CY: begin
                mul_a = 36'($signed(ny_reg[31:0]));
                mul_b = 34'($signed({1'b0, max_reg}));
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        sq_start = (cmd.st == avc_pkg::ST_SQD) || (cmd.st == avc_pkg::ST_SQV) ||
                   (cmd.st == avc_pkg::ST_SQS) || (cmd.st == avc_pkg::ST_SQH);
        sq_in    = (cmd.st == avc_pkg::ST_SQS) ? {prod_reg[62:0], 1'b0}
                                                : acc_reg + prod_reg[63:0];
        div_start = (cmd.st == avc_pkg::ST_DVX) || (cmd.st == avc_pkg::ST_DVY) ||
                    (cmd.st == avc_pkg::ST_CDX) || (cmd.st == avc_pkg::ST_CDY);
        div_n     = prod_reg[63:0];
        div_d     = ((cmd.st == avc_pkg::ST_CDX) || (cmd.st == avc_pkg::ST_CDY)) ? sp_reg
                                                                                 : dist_reg;
    end

    // CORDIC quadrant fold and output rounding
    always_comb begin
        ang     = {hd_reg, 16'h0000};
        ang_q   = 2'((ang + 32'h2000_0000) >> 30);
        ang_rem = ang - {ang_q, 30'd0};
        cs_w    = 20'((cx_reg + 34'sd8192) >>> 14);
        sn_w    = 20'((cy_reg + 34'sd8192) >>> 14);
        cs      = cs_w[17:0];
        sn      = sn_w[17:0];
    end

    avc_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sq_in),
        .done     (sq_done),
        .root     (sq_root)
    );

    avc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quot     (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg     <= avc_pkg::RST_MAX_SPEED;
            acc_lim_reg <= avc_pkg::RST_ACCEL;
            dec_lim_reg <= avc_pkg::RST_DECEL;
            tick_reg    <= avc_pkg::RST_TICK_TIME;
            arr_reg     <= avc_pkg::RST_ARRIVE;
            stop_reg    <= avc_pkg::RST_STOP_SPEED;
            gain_reg    <= avc_pkg::RST_GAIN;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                avc_pkg::REG_MAX_SPEED:  max_reg     <= cfg_data;
                avc_pkg::REG_ACCEL:      acc_lim_reg <= cfg_data;
                avc_pkg::REG_DECEL:      dec_lim_reg <= cfg_data;
                avc_pkg::REG_TICK_TIME:  tick_reg    <= cfg_data;
                avc_pkg::REG_ARRIVE:     arr_reg     <= cfg_data;
                avc_pkg::REG_STOP_SPEED: stop_reg    <= cfg_data;
                avc_pkg::REG_GAIN:       gain_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vx_reg      <= '0;
            vy_reg      <= '0;
            armed_reg   <= 1'b0;
            arrived_reg <= 1'b0;
        end else if (cmd.load) begin
            arrived_reg <= 1'b0;
            if (s_tuser == avc_pkg::ACT_ARM) begin
                armed_reg <= 1'b1;
            end
            if (s_tuser == avc_pkg::ACT_LOAD) begin
                vx_reg <= $signed(s_tdata[111:80]);
                vy_reg <= $signed(s_tdata[143:112]);
            end
        end else if (cmd.st == avc_pkg::ST_ARRIVE) begin
            vx_reg      <= '0;
            vy_reg      <= '0;
            armed_reg   <= 1'b0;
            arrived_reg <= 1'b1;
        end else if (cmd.st == avc_pkg::ST_WB) begin
            vx_reg <= nx_reg[31:0];
            vy_reg <= ny_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cbusy_reg <= 1'b0;
            cdone_reg <= 1'b0;
        end else begin
            cdone_reg <= cbusy_reg && (ci_reg == avc_pkg::CORDIC_LAST);
            if (cmd.st == avc_pkg::ST_ERR) begin
                cbusy_reg <= 1'b1;
            end else if (cbusy_reg && (ci_reg == avc_pkg::CORDIC_LAST)) begin
                cbusy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.st == avc_pkg::ST_ERR) begin
            cx_reg <= avc_pkg::CORDIC_GAIN;
            cy_reg <= '0;
            cz_reg <= 33'($signed(ang_rem));
            ci_reg <= '0;
            cq_reg <= ang_q;
        end else if (cbusy_reg) begin
            if (!cz_reg[32]) begin
                cx_reg <= cx_reg - (cy_reg >>> ci_reg);
                cy_reg <= cy_reg + (cx_reg >>> ci_reg);
                cz_reg <= cz_reg - $signed({3'b000, avc_pkg::atan_lut(ci_reg)});
            end else begin
                cx_reg <= cx_reg + (cy_reg >>> ci_reg);
                cy_reg <= cy_reg - (cx_reg >>> ci_reg);
                cz_reg <= cz_reg + $signed({3'b000, avc_pkg::atan_lut(ci_reg)});
            end
            ci_reg <= ci_reg + 5'd1;
        end
    end

    // working registers, stepped by the controller
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load) begin
            ox_reg <= $signed(s_tdata[31:0]);
            oy_reg <= $signed(s_tdata[63:32]);
            hd_reg <= s_tdata[79:64];
        end
        if (cmd.out_load) begin
            mdata_reg <= {vy_reg, vx_reg};
            muser_reg <= {armed_reg, arrived_reg};
        end
        unique case (cmd.st)
            avc_pkg::ST_SQY, avc_pkg::ST_VY, avc_pkg::ST_H2: acc_reg <= prod_reg[63:0];
            avc_pkg::ST_WD: if (sq_done) dist_reg <= sq_root;
            avc_pkg::ST_WV: if (sq_done) spd_reg <= sq_root;
            avc_pkg::ST_WS: begin
                if (sq_done) begin
                    ds_reg <= (sq_root > {1'b0, max_reg}) ? {1'b0, max_reg} : sq_root;
                end
            end
            avc_pkg::ST_WH: if (sq_done) sp_reg <= sq_root;
            avc_pkg::ST_CHK: begin
                dvx_reg <= '0;
                dvy_reg <= '0;
            end
            avc_pkg::ST_WX:  if (div_done) dvx_reg <= div_q;
            avc_pkg::ST_WY:  if (div_done) dvy_reg <= div_q;
            avc_pkg::ST_ERR: begin
                ex_reg <= 33'(dvx_reg) - 33'(vx_reg);
                ey_reg <= 33'(dvy_reg) - 33'(vy_reg);
            end
            avc_pkg::ST_WC: begin
                if (cdone_reg) begin
                    unique case (cq_reg)
                        2'd0: begin c_reg <= cs;  s_reg <= sn;  end
                        2'd1: begin c_reg <= -sn; s_reg <= cs;  end
                        2'd2: begin c_reg <= -cs; s_reg <= -sn; end
                        default: begin c_reg <= sn; s_reg <= -cs; end
                    endcase
                end
            end
            avc_pkg::ST_F2, avc_pkg::ST_F4, avc_pkg::ST_A2, avc_pkg::ST_A4:
                t_reg <= prod_reg[51:0];
            avc_pkg::ST_F3: fe_reg <= dif[51:16];
            avc_pkg::ST_F5: re_reg <= sum[51:16];
            avc_pkg::ST_G1: fa_reg <= clamp_acc(fe_reg[35], prod_reg[63:16], acc_lim_reg,
                                                dec_lim_reg);
            avc_pkg::ST_G2: ra_reg <= clamp_acc(re_reg[35], prod_reg[63:16], acc_lim_reg,
                                                acc_lim_reg);
            avc_pkg::ST_A3: ax_reg <= dif[50:16];
            avc_pkg::ST_A5: ay_reg <= sum[50:16];
            avc_pkg::ST_I1: nx_reg <= 51'(vx_reg) + prod_reg[66:16];
            avc_pkg::ST_I2: begin
                ny_reg <= 51'(vy_reg) + prod_reg[66:16];
                k_reg  <= 1'b0;
            end
            avc_pkg::ST_NRM: begin
                if (!sts.norm_ok) begin
                    nx_reg <= nx_reg >>> 1;
                    ny_reg <= ny_reg >>> 1;
                    k_reg  <= 1'b1;
                end
            end
            avc_pkg::ST_CWX: if (div_done) nx_reg <= 51'(div_q);
            avc_pkg::ST_CWY: if (div_done) ny_reg <= 51'(div_q);
            default: ;
        endcase
    end
endmodule

FILE: rtl/avc_ctrl.sv
// Controller: sequences one transaction through the datapath and owns the handshakes.
module avc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  avc_pkg::avc_sts_t sts,
    output avc_pkg::avc_cmd_t cmd
);
    avc_pkg::avc_state_t state_reg, state_next;
    logic                m_valid_reg, m_valid_next;

    assign s_tready = (state_reg == avc_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= avc_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd.st       = state_reg;
        cmd.load     = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            avc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.tick_go ? avc_pkg::ST_SQX : avc_pkg::ST_OUT;
                end
            end
            avc_pkg::ST_SQX: state_next = avc_pkg::ST_SQY;
            avc_pkg::ST_SQY: state_next = avc_pkg::ST_SQD;
            avc_pkg::ST_SQD: state_next = avc_pkg::ST_WD;
            avc_pkg::ST_WD:  if (sts.sq_done) state_next = avc_pkg::ST_VX;
            avc_pkg::ST_VX:  state_next = avc_pkg::ST_VY;
            avc_pkg::ST_VY:  state_next = avc_pkg::ST_SQV;
            avc_pkg::ST_SQV: state_next = avc_pkg::ST_WV;
            avc_pkg::ST_WV:  if (sts.sq_done) state_next = avc_pkg::ST_CHK;
            avc_pkg::ST_CHK: begin
                priority if (sts.arrive) state_next = avc_pkg::ST_ARRIVE;
                else if (sts.tiny)       state_next = avc_pkg::ST_ERR;
                else                     state_next = avc_pkg::ST_DD;
            end
            avc_pkg::ST_ARRIVE: state_next = avc_pkg::ST_OUT;
            avc_pkg::ST_DD:  state_next = avc_pkg::ST_SQS;
            avc_pkg::ST_SQS: state_next = avc_pkg::ST_WS;
            avc_pkg::ST_WS:  if (sts.sq_done) state_next = avc_pkg::ST_PX;
            avc_pkg::ST_PX:  state_next = avc_pkg::ST_DVX;
            avc_pkg::ST_DVX: state_next = avc_pkg::ST_WX;
            avc_pkg::ST_WX:  if (sts.div_done) state_next = avc_pkg::ST_PY;
            avc_pkg::ST_PY:  state_next = avc_pkg::ST_DVY;
            avc_pkg::ST_DVY: state_next = avc_pkg::ST_WY;
            avc_pkg::ST_WY:  if (sts.div_done) state_next = avc_pkg::ST_ERR;
            avc_pkg::ST_ERR: state_next = avc_pkg::ST_WC;
            avc_pkg::ST_WC:  if (sts.cs_done) state_next = avc_pkg::ST_F1;
            avc_pkg::ST_F1:  state_next = avc_pkg::ST_F2;
            avc_pkg::ST_F2:  state_next = avc_pkg::ST_F3;
            avc_pkg::ST_F3:  state_next = avc_pkg::ST_F4;
            avc_pkg::ST_F4:  state_next = avc_pkg::ST_F5;
            avc_pkg::ST_F5:  state_next = avc_pkg::ST_G1;
            avc_pkg::ST_G1:  state_next = avc_pkg::ST_G2;
            avc_pkg::ST_G2:  state_next = avc_pkg::ST_A1;
            avc_pkg::ST_A1:  state_next = avc_pkg::ST_A2;
            avc_pkg::ST_A2:  state_next = avc_pkg::ST_A3;
            avc_pkg::ST_A3:  state_next = avc_pkg::ST_A4;
            avc_pkg::ST_A4:  state_next = avc_pkg::ST_A5;
            avc_pkg::ST_A5:  state_next = avc_pkg::ST_I1;
            avc_pkg::ST_I1:  state_next = avc_pkg::ST_I2;
            avc_pkg::ST_I2:  state_next = avc_pkg::ST_NRM;
            avc_pkg::ST_NRM: if (sts.norm_ok) state_next = avc_pkg::ST_H1;
            avc_pkg::ST_H1:  state_next = avc_pkg::ST_H2;
            avc_pkg::ST_H2:  state_next = avc_pkg::ST_SQH;
            avc_pkg::ST_SQH: state_next = avc_pkg::ST_WH;
            avc_pkg::ST_WH:  if (sts.sq_done) state_next = avc_pkg::ST_CAP;
            avc_pkg::ST_CAP: state_next = sts.need_cap ? avc_pkg::ST_CX : avc_pkg::ST_WB;
            avc_pkg::ST_CX:  state_next = avc_pkg::ST_CDX;
            avc_pkg::ST_CDX: state_next = avc_pkg::ST_CWX;
            avc_pkg::ST_CWX: if (sts.div_done) state_next = avc_pkg::ST_CY;
            avc_pkg::ST_CY:  state_next = avc_pkg::ST_CDY;
            avc_pkg::ST_CDY: state_next = avc_pkg::ST_CWY;
            avc_pkg::ST_CWY: if (sts.div_done) state_next = avc_pkg::ST_WB;
            avc_pkg::ST_WB:  state_next = avc_pkg::ST_OUT;
            avc_pkg::ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = avc_pkg::ST_IDLE;
                end
            end
            default: state_next = avc_pkg::ST_IDLE;
        endcase
    end
endmodule

FILE: rtl/arrival_velocity_controller_top.sv
// Top level of the arrival velocity controller.
//
// Input channel s_*: one transaction per command. s_tuser carries the action
// (tick, arm move target, load velocity); s_tdata carries offsets, heading and
// the velocity to load. Output channel m_*: one transaction per input, holding
// the velocity after the command plus the arrived and armed flags.
// Config channel cfg_*: register index and 31-bit value, always ready; write
// only while the block is idle.
// One command is worked on at a time. Arm, load, idle ticks and unused codes
// go straight to the output register. An armed tick that declares arrival
// computes two roots; a steering tick uses the square-root unit (up to four
// roots), the divider (up to four quotients) and the 24-step CORDIC.
// The result sits in an output register, so the next command is accepted
// while the receiver stalls; the block then waits at the end of that command
// until the register is free.
// Reset clears the velocity, the armed flag, the output valid and restores the
// register defaults.
module arrival_velocity_controller_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // offset_x, offset_y, heading, load_vx, load_vy
    input  logic [1:0]   s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // vel_x, vel_y
    output logic [1:0]   m_tuser,   // arrived, armed
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_addr,
    input  logic [30:0]  cfg_data
);
    avc_pkg::avc_cmd_t cmd;
    avc_pkg::avc_sts_t sts;

    assign cfg_ready = 1'b1;

    avc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    avc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );
endmodule

FILE: rtl/avc_checker.sv
// Port-level checks of the arrival velocity controller, bound to the top level.
module avc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [143:0] s_tdata,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata,
    input logic [1:0]   m_tuser,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [2:0]   cfg_addr,
    input logic [30:0]  cfg_data
);
    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output transaction changed");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    a_arrive_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 64'd0 && !m_tuser[1])
        else $error("arrival without zero velocity and disarm");
endmodule

bind arrival_velocity_controller_top avc_checker u_avc_checker (.*);
